// ===== rtl/calendar_difference_seconds_defines.svh =====
// Assertion macros shared by the calendar difference modules.
// Depends on nothing; each user supplies aclk and aresetn in scope.
`ifndef CALENDAR_DIFFERENCE_SECONDS_DEFINES_SVH
`define CALENDAR_DIFFERENCE_SECONDS_DEFINES_SVH
`ifndef SYNTH
// Checked property, muted while reset is held.
`define CDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked property, live during reset as well.
`define CDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CDS_ASSERT(lbl, prop, msg)
`define CDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/cds_pkg.sv =====
// Types, widths and the month table for the calendar difference block.
// Used by the controller, the datapath and the top level.
package cds_pkg;

    localparam int YEAR_BITS = 12;
    localparam int OUT_BITS  = 38;
    // Day accumulator: 366 * 2^YEAR_BITS stays below 2^(YEAR_BITS+9).
    localparam int ACC_BITS  = YEAR_BITS + 9;
    localparam int DAY_BITS  = ACC_BITS + 1;
    // 86400 and the time of day both fit in 17 bits.
    localparam int TOD_BITS  = 17;
    localparam int SEC_BITS  = DAY_BITS + 18;

    localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;
    localparam logic signed [63:0] OUT_MAX = 64'sd137438953471;
    localparam logic signed [63:0] OUT_MIN = -64'sd137438953472;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DAYS_A,
        ST_SECS_A,
        ST_DAYS_B,
        ST_SECS_B,
        ST_WRITE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sweep_step;
        logic calc_days;
        logic calc_secs;
        logic sel;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;
        logic out_busy;
    } stat_t;

    // Days in the whole months before a month of a common year.
    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd0, 4'd1: d = 9'd0;
            4'd2:       d = 9'd31;
            4'd3:       d = 9'd59;
            4'd4:       d = 9'd90;
            4'd5:       d = 9'd120;
            4'd6:       d = 9'd151;
            4'd7:       d = 9'd181;
            4'd8:       d = 9'd212;
            4'd9:       d = 9'd243;
            4'd10:      d = 9'd273;
            4'd11:      d = 9'd304;
            4'd12:      d = 9'd334;
            default:    d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/calendar_difference_seconds.sv =====
// Top level of the calendar difference block: controller and datapath.
// Depends on cds_pkg, cds_ctrl and cds_datapath.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  first_* and second_* date-time fields
//   m_       out  m_valid / m_ready  m_seconds_difference, 38 bits signed
//
// The time from acceptance to the result being offered grows with max(first_year,
// second_year), set by the year sweep that counts days one year a cycle.
// The block is back in idle as the result is offered.
// Input is taken only in idle; the next beat may enter while a result waits.
// A result that is not taken stalls the block before it loads the next one.
// Reset (aresetn low at a clock edge) returns to idle and drops the result.
module calendar_difference_seconds
    import cds_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [YEAR_BITS-1:0]       s_first_year,
    input  logic [3:0]                 s_first_month,
    input  logic [4:0]                 s_first_day,
    input  logic [4:0]                 s_first_hour,
    input  logic [5:0]                 s_first_minute,
    input  logic [5:0]                 s_first_second,
    input  logic [YEAR_BITS-1:0]       s_second_year,
    input  logic [3:0]                 s_second_month,
    input  logic [4:0]                 s_second_day,
    input  logic [4:0]                 s_second_hour,
    input  logic [5:0]                 s_second_minute,
    input  logic [5:0]                 s_second_second,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_BITS-1:0] m_seconds_difference
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    cds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and result register.
    cds_datapath u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .s_first_year         (s_first_year),
        .s_first_month        (s_first_month),
        .s_first_day          (s_first_day),
        .s_first_hour         (s_first_hour),
        .s_first_minute       (s_first_minute),
        .s_first_second       (s_first_second),
        .s_second_year        (s_second_year),
        .s_second_month       (s_second_month),
        .s_second_day         (s_second_day),
        .s_second_hour        (s_second_hour),
        .s_second_minute      (s_second_minute),
        .s_second_second      (s_second_second),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_seconds_difference (m_seconds_difference)
    );

endmodule

// ===== rtl/cds_ctrl.sv =====
// Sequencing state machine for the calendar difference block.
// Depends on cds_pkg and the assertion macro header.
`include "calendar_difference_seconds_defines.svh"
module cds_ctrl
    import cds_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_done) begin
                    state_next = ST_DAYS_A;
                end
            end
            ST_DAYS_A: begin
                cmd.calc_days = 1'b1;
                state_next    = ST_SECS_A;
            end
            ST_SECS_A: begin
                cmd.calc_secs = 1'b1;
                state_next    = ST_DAYS_B;
            end
            ST_DAYS_B: begin
                cmd.calc_days = 1'b1;
                cmd.sel       = 1'b1;
                state_next    = ST_SECS_B;
            end
            ST_SECS_B: begin
                cmd.calc_secs = 1'b1;
                cmd.sel       = 1'b1;
                state_next    = ST_WRITE;
            end
            ST_WRITE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A beat taken in idle always starts the year sweep.
    `CDS_ASSERT(a_accept_sweeps, s_valid && s_ready |=> state_reg == ST_SWEEP, "accept without sweep")
    // The sweep hands over to the first date's day count once it ends.
    `CDS_ASSERT(a_sweep_exit, state_reg == ST_SWEEP && stat.sweep_done |=> state_reg == ST_DAYS_A, "sweep exit lost")
    // The result is never loaded while the output still holds an untaken beat.
    `CDS_ASSERT(a_no_overwrite, cmd.out_load |-> !stat.out_busy, "result overwritten")

endmodule

// ===== rtl/cds_datapath.sv =====
// Datapath: input capture, year sweep, seconds conversion and result register.
// Depends on cds_pkg and the assertion macro header.
`include "calendar_difference_seconds_defines.svh"
module cds_datapath
    import cds_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    input  logic [YEAR_BITS-1:0]       s_first_year,
    input  logic [3:0]                 s_first_month,
    input  logic [4:0]                 s_first_day,
    input  logic [4:0]                 s_first_hour,
    input  logic [5:0]                 s_first_minute,
    input  logic [5:0]                 s_first_second,
    input  logic [YEAR_BITS-1:0]       s_second_year,
    input  logic [3:0]                 s_second_month,
    input  logic [4:0]                 s_second_day,
    input  logic [4:0]                 s_second_hour,
    input  logic [5:0]                 s_second_minute,
    input  logic [5:0]                 s_second_second,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_BITS-1:0] m_seconds_difference
);

    // Captured beat.
    logic [YEAR_BITS-1:0] year_a_reg, year_b_reg, year_max_reg;
    logic [3:0]           month_a_reg, month_b_reg;
    logic [4:0]           day_a_reg, day_b_reg, hour_a_reg, hour_b_reg;
    logic [5:0]           min_a_reg, min_b_reg, sec_a_reg, sec_b_reg;

    // Year sweep.
    logic [YEAR_BITS-1:0] year_cnt_reg;
    logic [ACC_BITS-1:0]  acc_reg;
    logic [1:0]           mod4_reg;
    logic [6:0]           mod100_reg;
    logic [8:0]           mod400_reg;
    logic [ACC_BITS-1:0]  dby_a_reg, dby_b_reg;
    logic                 leap_a_reg, leap_b_reg;
    logic                 leap_now;

    // Conversion.
    logic signed [DAY_BITS-1:0] days_reg;
    logic signed [DAY_BITS-1:0] days_next;
    logic [TOD_BITS-1:0]        tod_reg;
    logic [TOD_BITS-1:0]        tod_next;
    logic signed [SEC_BITS-1:0] secs_a_reg, secs_b_reg;
    logic signed [SEC_BITS-1:0] prod;
    logic signed [SEC_BITS-1:0] secs_next;
    logic signed [SEC_BITS:0]   diff;
    logic signed [63:0]         diff_wide;
    logic signed [OUT_BITS-1:0] res_next;

    // Selected date for the conversion steps.
    logic [ACC_BITS-1:0] dby_sel;
    logic                leap_sel;
    logic [3:0]          month_sel;
    logic [4:0]          day_sel, hour_sel;
    logic [5:0]          min_sel, sec_sel;

    logic out_valid_reg;
    logic signed [OUT_BITS-1:0] out_reg;

    assign leap_now = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign stat.sweep_done = (year_cnt_reg == year_max_reg);
    assign stat.out_busy   = out_valid_reg && !m_ready;

    // Capture the beat and run the sweep from year zero up to the later year.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            year_a_reg   <= s_first_year;
            month_a_reg  <= s_first_month;
            day_a_reg    <= s_first_day;
            hour_a_reg   <= s_first_hour;
            min_a_reg    <= s_first_minute;
            sec_a_reg    <= s_first_second;
            year_b_reg   <= s_second_year;
            month_b_reg  <= s_second_month;
            day_b_reg    <= s_second_day;
            hour_b_reg   <= s_second_hour;
            min_b_reg    <= s_second_minute;
            sec_b_reg    <= s_second_second;
            year_max_reg <= (s_first_year > s_second_year) ? s_first_year : s_second_year;
            year_cnt_reg <= '0;
            acc_reg      <= '0;
            mod4_reg     <= '0;
            mod100_reg   <= '0;
            mod400_reg   <= '0;
        end else if (cmd.sweep_step) begin
            if (year_cnt_reg == year_a_reg) begin
                dby_a_reg  <= acc_reg;
                leap_a_reg <= leap_now;
            end
            if (year_cnt_reg == year_b_reg) begin
                dby_b_reg  <= acc_reg;
                leap_b_reg <= leap_now;
            end
            if (!stat.sweep_done) begin
                year_cnt_reg <= year_cnt_reg + YEAR_BITS'(1);
                acc_reg      <= acc_reg + ACC_BITS'(365) + ACC_BITS'(leap_now);
                mod4_reg     <= mod4_reg + 2'd1;
                mod100_reg   <= (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                mod400_reg   <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
            end
        end
    end

    // Pick the date that the current step works on.
    always_comb begin
        dby_sel   = cmd.sel ? dby_b_reg   : dby_a_reg;
        leap_sel  = cmd.sel ? leap_b_reg  : leap_a_reg;
        month_sel = cmd.sel ? month_b_reg : month_a_reg;
        day_sel   = cmd.sel ? day_b_reg   : day_a_reg;
        hour_sel  = cmd.sel ? hour_b_reg  : hour_a_reg;
        min_sel   = cmd.sel ? min_b_reg   : min_a_reg;
        sec_sel   = cmd.sel ? sec_b_reg   : sec_a_reg;
    end

    // Day count and time of day; day zero lands one day before day one.
    always_comb begin
        days_next = DAY_BITS'(dby_sel) + DAY_BITS'(days_before_month(month_sel))
                  + DAY_BITS'((month_sel > 4'd2) && leap_sel)
                  + DAY_BITS'(day_sel) - DAY_BITS'(1);
        tod_next  = TOD_BITS'(hour_sel) * TOD_BITS'(3600)
                  + TOD_BITS'(min_sel) * TOD_BITS'(60)
                  + TOD_BITS'(sec_sel);
    end

    // Seconds from the registered day count.
    assign prod      = SEC_BITS'(days_reg) * SEC_BITS'(SECS_PER_DAY);
    assign secs_next = prod + SEC_BITS'(tod_reg);

    always_ff @(posedge aclk) begin
        if (cmd.calc_days) begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
        end
        if (cmd.calc_secs && !cmd.sel) begin
            secs_a_reg <= secs_next;
        end
        if (cmd.calc_secs && cmd.sel) begin
            secs_b_reg <= secs_next;
        end
    end

    // Difference, clamped to the output range.
    always_comb begin
        diff      = (SEC_BITS+1)'(secs_a_reg) - (SEC_BITS+1)'(secs_b_reg);
        diff_wide = 64'(diff);
        if (diff_wide > OUT_MAX) begin
            res_next = OUT_MAX[OUT_BITS-1:0];
        end else if (diff_wide < OUT_MIN) begin
            res_next = OUT_MIN[OUT_BITS-1:0];
        end else begin
            res_next = diff_wide[OUT_BITS-1:0];
        end
    end

    // Output register; holds the beat until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= res_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_seconds_difference = out_reg;

    // The sweep restarts from year zero with an empty day count.
    `CDS_ASSERT(a_load_clears, cmd.load |=> year_cnt_reg == '0 && acc_reg == '0, "sweep not cleared")
    // Each sweep step that is not the last moves on by exactly one year.
    `CDS_ASSERT(a_sweep_inc, cmd.sweep_step && !stat.sweep_done |=> year_cnt_reg == $past(year_cnt_reg) + YEAR_BITS'(1), "sweep skipped a year")
    // A loaded result is offered on the next cycle.
    `CDS_ASSERT(a_load_valid, cmd.out_load |=> m_valid, "loaded result not offered")
    // Nothing is offered straight out of reset.
    `CDS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "valid after reset")

endmodule

// ===== tb/sv/tb_calendar_difference_seconds.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for calendar_difference_seconds: directed and random date pairs.
// Depends on cds_pkg and the calendar_difference_seconds top level.
module tb_calendar_difference_seconds
    import cds_pkg::*;
();

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 6;
    localparam int RANDOM_LEN  = 120;
    localparam int DRAIN_LEN   = 4200;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam longint DAY_SECS = 86400;

    // One broken-down date-time as carried by the input ports.
    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [3:0]           month;
        logic [4:0]           day;
        logic [4:0]           hour;
        logic [5:0]           minute;
        logic [5:0]           second;
    } stamp_t;

    typedef struct packed {
        stamp_t first;
        stamp_t second;
    } date_pair_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [YEAR_BITS-1:0]       s_first_year = '0;
    logic [3:0]                 s_first_month = '0;
    logic [4:0]                 s_first_day = '0;
    logic [4:0]                 s_first_hour = '0;
    logic [5:0]                 s_first_minute = '0;
    logic [5:0]                 s_first_second = '0;
    logic [YEAR_BITS-1:0]       s_second_year = '0;
    logic [3:0]                 s_second_month = '0;
    logic [4:0]                 s_second_day = '0;
    logic [4:0]                 s_second_hour = '0;
    logic [5:0]                 s_second_minute = '0;
    logic [5:0]                 s_second_second = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [OUT_BITS-1:0] m_seconds_difference;

    date_pair_t                 pending_dates[$];
    logic signed [OUT_BITS-1:0] expected_diffs[$];
    logic                       in_taken = 1'b0;
    int                         total_items = 0;
    int                         beats_in = 0;
    int                         beats_out = 0;
    int                         mismatches = 0;
    int                         cycles = 0;
    int                         send_idle_pct;
    int                         take_idle_pct;

    calendar_difference_seconds u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_first_year         (s_first_year),
        .s_first_month        (s_first_month),
        .s_first_day          (s_first_day),
        .s_first_hour         (s_first_hour),
        .s_first_minute       (s_first_minute),
        .s_first_second       (s_first_second),
        .s_second_year        (s_second_year),
        .s_second_month       (s_second_month),
        .s_second_day         (s_second_day),
        .s_second_hour        (s_second_hour),
        .s_second_minute      (s_second_minute),
        .s_second_second      (s_second_second),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_seconds_difference (m_seconds_difference)
    );

    // Free-running clock.
    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Length of a month in a common year; months past December are empty.
    function automatic longint month_length(input int month);
        case (month)
            2:              return 28;
            4, 6, 9, 11:    return 30;
            13, 14, 15:     return 0;
            default:        return 31;
        endcase
    endfunction

    function automatic bit is_leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Seconds from the start of 1 January of year 0 to the given date-time.
    function automatic longint stamp_seconds(input stamp_t t);
        longint y;
        longint days;
        y    = longint'(t.year);
        days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int m = 1; m < int'(t.month); m++)
            days += month_length(m);
        if (t.month > 4'd2 && is_leap_year(y))
            days += 1;
        days += longint'(t.day) - 1;
        return days * DAY_SECS + longint'(t.hour) * 3600 + longint'(t.minute) * 60
               + longint'(t.second);
    endfunction

    // Signed first-minus-second difference, clamped to the output range.
    function automatic logic signed [OUT_BITS-1:0] predict_difference(input date_pair_t p);
        longint diff;
        diff = stamp_seconds(p.first) - stamp_seconds(p.second);
        if (diff > OUT_MAX)
            diff = OUT_MAX;
        if (diff < OUT_MIN)
            diff = OUT_MIN;
        return diff[OUT_BITS-1:0];
    endfunction

    function automatic stamp_t make_stamp(input int y, input int mo, input int d,
                                          input int h, input int mi, input int s);
        stamp_t t;
        t.year   = y[YEAR_BITS-1:0];
        t.month  = mo[3:0];
        t.day    = d[4:0];
        t.hour   = h[4:0];
        t.minute = mi[5:0];
        t.second = s[5:0];
        return t;
    endfunction

    // Years stay small for most beats, since the sweep costs a cycle per year.
    function automatic int pick_year();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return $urandom_range(0, (1 << YEAR_BITS) - 1);
        else if (r < 30)
            return $urandom_range(1900, 2100);
        else
            return $urandom_range(0, 255);
    endfunction

    function automatic stamp_t sane_stamp();
        return make_stamp(pick_year(), $urandom_range(1, 12), $urandom_range(1, 31),
                          $urandom_range(0, 23), $urandom_range(0, 59),
                          $urandom_range(0, 59));
    endfunction

    function automatic stamp_t wild_stamp();
        return make_stamp(pick_year(), $urandom_range(0, 15), $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 63),
                          $urandom_range(0, 63));
    endfunction

    task automatic queue_pair(input stamp_t a, input stamp_t b);
        date_pair_t p;
        p.first  = a;
        p.second = b;
        pending_dates.push_back(p);
    endtask

    // Idle rates follow the phase of the run, set by the beats accepted so far.
    always_comb begin
        if (beats_in < total_items / 3) begin
            send_idle_pct = 16;
            take_idle_pct = 84;
        end else if (beats_in < (2 * total_items) / 3) begin
            send_idle_pct = 84;
            take_idle_pct = 16;
        end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
        end
    end

    // Driver: presents the next pending pair on the falling edge.
    always @(negedge aclk) begin : driver
        date_pair_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_dates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_dates.pop_front();
                s_first_year    <= nxt.first.year;
                s_first_month   <= nxt.first.month;
                s_first_day     <= nxt.first.day;
                s_first_hour    <= nxt.first.hour;
                s_first_minute  <= nxt.first.minute;
                s_first_second  <= nxt.first.second;
                s_second_year   <= nxt.second.year;
                s_second_month  <= nxt.second.month;
                s_second_day    <= nxt.second.day;
                s_second_hour   <= nxt.second.hour;
                s_second_minute <= nxt.second.minute;
                s_second_second <= nxt.second.second;
                s_valid         <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= take_idle_pct);
    end

    // Monitor: checks result beats first, then records the prediction for an input beat.
    always @(posedge aclk) begin : monitor
        date_pair_t seen;
        logic signed [OUT_BITS-1:0] want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (expected_diffs.size() == 0) begin
                    $error("result beat with no expectation: %0d", m_seconds_difference);
                    mismatches++;
                end else begin
                    want = expected_diffs.pop_front();
                    if (m_seconds_difference !== want) begin
                        $error("seconds_difference: expected %0d, actual %0d",
                               want, m_seconds_difference);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                seen.first  = make_stamp(s_first_year, s_first_month, s_first_day,
                                         s_first_hour, s_first_minute, s_first_second);
                seen.second = make_stamp(s_second_year, s_second_month, s_second_day,
                                         s_second_hour, s_second_minute, s_second_second);
                expected_diffs.push_back(predict_difference(seen));
                beats_in++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        stamp_t a;
        stamp_t b;
        int     kind;
        int     field;

        // Directed pairs: range extremes, leap rules and out-of-range fields.
        queue_pair(make_stamp(2000, 1, 1, 0, 0, 0), make_stamp(2000, 1, 1, 0, 0, 0));
        queue_pair(make_stamp(0, 1, 1, 0, 0, 0), make_stamp(4095, 12, 31, 23, 59, 59));
        queue_pair(make_stamp(4095, 12, 31, 23, 59, 59), make_stamp(0, 1, 1, 0, 0, 0));
        queue_pair(make_stamp(4095, 15, 31, 31, 63, 63), make_stamp(0, 0, 0, 0, 0, 0));
        queue_pair(make_stamp(0, 0, 0, 0, 0, 0), make_stamp(4095, 15, 31, 31, 63, 63));
        // Month zero counts as January.
        queue_pair(make_stamp(2001, 0, 5, 10, 0, 0), make_stamp(2001, 1, 5, 10, 0, 0));
        // Months past December lie after the whole year.
        queue_pair(make_stamp(2001, 13, 1, 0, 0, 0), make_stamp(2002, 1, 1, 0, 0, 0));
        queue_pair(make_stamp(2000, 14, 1, 0, 0, 0), make_stamp(2000, 12, 31, 0, 0, 0));
        queue_pair(make_stamp(2004, 15, 3, 1, 2, 3), make_stamp(2003, 13, 3, 1, 2, 3));
        // Day zero is the day before the first.
        queue_pair(make_stamp(2001, 3, 0, 0, 0, 0), make_stamp(2001, 2, 28, 0, 0, 0));
        queue_pair(make_stamp(0, 1, 0, 0, 0, 0), make_stamp(0, 1, 1, 0, 0, 0));
        // Leap years: plain, century, four-century and year zero.
        queue_pair(make_stamp(2024, 3, 1, 0, 0, 0), make_stamp(2024, 2, 28, 0, 0, 0));
        queue_pair(make_stamp(1900, 3, 1, 0, 0, 0), make_stamp(1900, 2, 28, 0, 0, 0));
        queue_pair(make_stamp(2000, 3, 1, 0, 0, 0), make_stamp(2000, 2, 28, 0, 0, 0));
        queue_pair(make_stamp(400, 3, 1, 0, 0, 0), make_stamp(400, 2, 28, 0, 0, 0));
        queue_pair(make_stamp(0, 3, 1, 0, 0, 0), make_stamp(0, 2, 28, 0, 0, 0));
        queue_pair(make_stamp(100, 12, 31, 0, 0, 0), make_stamp(100, 1, 1, 0, 0, 0));
        // Time fields above their range carry their full weight.
        queue_pair(make_stamp(10, 6, 15, 31, 63, 63), make_stamp(10, 6, 15, 0, 0, 0));
        // One second across a year boundary, both ways.
        queue_pair(make_stamp(1999, 12, 31, 23, 59, 59), make_stamp(2000, 1, 1, 0, 0, 0));
        queue_pair(make_stamp(2000, 1, 1, 0, 0, 0), make_stamp(1999, 12, 31, 23, 59, 59));
        queue_pair(make_stamp(37, 7, 4, 12, 30, 1), make_stamp(37, 7, 4, 12, 29, 59));

        // Random pairs: mostly well-formed, some close pairs, the rest wild fields.
        for (int i = 0; i < RANDOM_LEN; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                a = sane_stamp();
                b = sane_stamp();
            end else if (kind < 85) begin
                a = sane_stamp();
                b = a;
                field = $urandom_range(0, 5);
                case (field)
                    0: b.year   = a.year + YEAR_BITS'($urandom_range(0, 2)) - YEAR_BITS'(1);
                    1: b.month  = 4'($urandom_range(1, 12));
                    2: b.day    = 5'($urandom_range(1, 31));
                    3: b.hour   = 5'($urandom_range(0, 23));
                    4: b.minute = 6'($urandom_range(0, 59));
                    default: b.second = 6'($urandom_range(0, 59));
                endcase
            end else begin
                a = wild_stamp();
                b = wild_stamp();
            end
            queue_pair(a, b);
        end
        total_items = pending_dates.size();

        // Synchronous reset, released on a falling edge.
        repeat (RESET_LEN) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: every beat sent and answered, then a quiet spell for stray results.
        while (pending_dates.size() != 0 || s_valid || expected_diffs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_LEN) @(posedge aclk);

        $display("Run covered %0d date pairs (%0d directed) and %0d result beats.",
                 total_items, total_items - RANDOM_LEN, beats_out);
        $display("Mismatches: %0d, cycles used: %0d.", mismatches, cycles);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
